/* sv/mexp_pkg.sv */
// Shared types for the modular exponentiation unit.
// No dependencies; compile before the interfaces and all modules.
package mexp_pkg;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_REDUCE  = 6'b000010,
      ST_WAIT    = 6'b000100,
      ST_ACC_MUL = 6'b001000,
      ST_SQ_MUL  = 6'b010000,
      ST_FINISH  = 6'b100000
   } mexp_state_type;

   // Register that receives the remainder of the running reduction
   typedef enum logic [1:0] {
      TGT_BASE = 2'd0,
      TGT_ACC  = 2'd1,
      TGT_SQ   = 2'd2
   } mexp_target_type;

   // Status of the serial remainder unit
   typedef struct packed {
      logic busy;
      logic done;
   } mexp_rem_stat_type;

endpackage

/* sv/mexp_if.sv */
// Valid/ready channel interfaces of the modular exponentiation unit.
// No dependencies; compile after mexp_pkg.
interface mexp_req_if #(parameter int WIDTH = 32);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] base_value;
   logic [WIDTH-1:0] exponent;

   modport source (output valid, output base_value, output exponent, input ready);
   modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_rsp_if #(parameter int WIDTH = 32);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] power_result;
   logic             modulus_error;

   modport source (output valid, output power_result, output modulus_error, input ready);
   modport sink   (input valid, input power_result, input modulus_error, output ready);
endinterface

interface mexp_csr_if #(parameter int WIDTH = 32);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] modulus;

   modport source (output valid, output modulus, input ready);
   modport sink   (input valid, input modulus, output ready);
endinterface

/* sv/mexp_rem.sv */
// Serial remainder unit: 2*WIDTH-bit dividend modulo WIDTH-bit divisor, one bit a cycle.
// Depends on mexp_pkg for the status struct.
module mexp_rem #(
   parameter int WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [2*WIDTH-1:0]         dividend,
   input  logic [WIDTH-1:0]           divisor,
   output mexp_pkg::mexp_rem_stat_type stat,
   output logic [WIDTH-1:0]           remainder
);
   import mexp_pkg::*;

   localparam int NUM_W = 2 * WIDTH;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [WIDTH-1:0] div_ff, div_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   div_ext;

   // Bring down the next dividend bit
   assign trial   = {rem_ff, num_ff[NUM_W-1]};
   assign div_ext = {1'b0, div_ff};

   // Load on start, then one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (trial >= div_ext) begin
            rem_in = WIDTH'(trial - div_ext);
         end else begin
            rem_in = WIDTH'(trial);
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

/* sv/modular_exponentiation_unit.sv */
// Top level of the modular exponentiation unit: sequencer, shared multiplier, output register.
// Depends on mexp_pkg, the channel interfaces in mexp_if and the remainder unit mexp_rem.
//
// Computes base_value ** exponent mod modulus by right-to-left square-and-multiply, one
// item at a time. Every modular product is one registered WIDTH x WIDTH multiply followed
// by a bit-serial remainder pass over the 2*WIDTH-bit product. An item does one reduction
// of the base, then per exponent bit up to its highest set bit one multiply (only when the
// bit is one) and one square (skipped after the highest set bit). A zero modulus or zero
// exponent goes straight to the finish state without a reduction.
// req.ready is high only while the sequencer is idle; a finished result waits in the
// output register while the next item is taken. The modulus register resets to 1 and
// accepts writes at any time, but should be written only while the unit is idle.
module modular_exponentiation_unit #(
   parameter int WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   mexp_req_if.sink   req,
   mexp_rsp_if.source rsp,
   mexp_csr_if.sink   csr
);
   import mexp_pkg::*;

   localparam int PROD_W = 2 * WIDTH;

   mexp_state_type    state_ff, state_in;
   mexp_target_type   tgt_ff, tgt_in;
   logic [WIDTH-1:0]  modulus_ff, modulus_in;
   logic [WIDTH-1:0]  exp_ff, exp_in;
   logic [WIDTH-1:0]  acc_ff, acc_in;
   logic [WIDTH-1:0]  sq_ff, sq_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              err_ff, err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]  out_result_ff, out_result_in;
   logic              out_error_ff, out_error_in;

   logic              req_fire;
   logic              csr_fire;
   logic              out_free;
   logic              rem_start;
   mexp_rem_stat_type rem_stat;
   logic [WIDTH-1:0]  rem_value;
   logic [WIDTH-1:0]  mul_a;
   logic [PROD_W-1:0] mul_prod;

   assign req.ready = (state_ff == ST_IDLE) && !rem_stat.busy;
   assign csr.ready = 1'b1;
   assign req_fire  = req.valid && req.ready;
   assign csr_fire  = csr.valid && csr.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign rem_start = (state_ff == ST_REDUCE);

   // Shared multiplier operand: accumulator for a multiply, square otherwise
   assign mul_a    = (state_ff == ST_ACC_MUL) ? acc_ff : sq_ff;
   assign mul_prod = PROD_W'(mul_a) * PROD_W'(sq_ff);

   mexp_rem #(
      .WIDTH (WIDTH)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (prod_ff),
      .divisor   (modulus_ff),
      .stat      (rem_stat),
      .remainder (rem_value)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      tgt_in        = tgt_ff;
      modulus_in    = modulus_ff;
      exp_in        = exp_ff;
      acc_in        = acc_ff;
      sq_in         = sq_ff;
      prod_in       = prod_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_result_in = out_result_ff;
      out_error_in  = out_error_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_fire) begin
         modulus_in = csr.modulus;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               exp_in = req.exponent;
               acc_in = WIDTH'(1);
               err_in = 1'b0;
               if (modulus_ff == '0) begin
                  // Zero modulus: flag it, result zero
                  acc_in   = '0;
                  err_in   = 1'b1;
                  state_in = ST_FINISH;
               end else if (req.exponent == '0) begin
                  // Zero exponent: one, not reduced
                  state_in = ST_FINISH;
               end else begin
                  prod_in  = PROD_W'(req.base_value);
                  tgt_in   = TGT_BASE;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (rem_stat.done) begin
               unique case (tgt_ff)
                  TGT_BASE: begin
                     sq_in    = rem_value;
                     state_in = exp_ff[0] ? ST_ACC_MUL : ST_SQ_MUL;
                  end
                  TGT_ACC: begin
                     acc_in = rem_value;
                     if (exp_ff[WIDTH-1:1] == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_SQ_MUL;
                     end
                  end
                  TGT_SQ: begin
                     // Advance to the next exponent bit
                     sq_in    = rem_value;
                     exp_in   = {1'b0, exp_ff[WIDTH-1:1]};
                     state_in = exp_ff[1] ? ST_ACC_MUL : ST_SQ_MUL;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ACC_MUL: begin
            prod_in  = mul_prod;
            tgt_in   = TGT_ACC;
            state_in = ST_REDUCE;
         end
         ST_SQ_MUL: begin
            prod_in  = mul_prod;
            tgt_in   = TGT_SQ;
            state_in = ST_REDUCE;
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_result_in = acc_ff;
               out_error_in  = err_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= WIDTH'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      tgt_ff        <= tgt_in;
      exp_ff        <= exp_in;
      acc_ff        <= acc_in;
      sq_ff         <= sq_in;
      prod_ff       <= prod_in;
      err_ff        <= err_in;
      out_result_ff <= out_result_in;
      out_error_ff  <= out_error_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.power_result  = out_result_ff;
   assign rsp.modulus_error = out_error_ff;

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the modular exponentiation unit.
// Depends on the RTL package, the channel interfaces in mexp_if and the unit's top level.
`timescale 1ns / 100ps

module tb_top;

   localparam int WIDTH       = 32;
   localparam int HOLD_CYCLES = 3000;
   localparam int WATCHDOG    = 40000;

   // Expected fields of one result item
   typedef struct {
      logic [WIDTH-1:0] power_result;
      logic             modulus_error;
   } mexp_outcome_type;

   // Predicts power results and checks them in order of arrival
   class power_board_type;
      logic [WIDTH-1:0] modulus;
      mexp_outcome_type owed_results[$];
      int               mismatches;
      int               results_seen;

      function new();
         modulus      = 1;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function void set_modulus(logic [WIDTH-1:0] value);
         modulus = value;
      endfunction

      // Square-and-multiply over all exponent bits, 64-bit products
      function mexp_outcome_type predict_power(logic [WIDTH-1:0] b, logic [WIDTH-1:0] e);
         mexp_outcome_type outcome;
         logic [63:0]      acc;
         logic [63:0]      sq;
         logic [63:0]      m;
         m = {32'd0, modulus};
         if (m == 0) begin
            outcome.power_result  = '0;
            outcome.modulus_error = 1'b1;
            return outcome;
         end
         acc = 64'd1;
         // a zero exponent leaves 1 unreduced, even for a modulus of one
         if (e != 0) begin
            sq = {32'd0, b} % m;
            for (int i = 0; i < WIDTH; i++) begin
               if (e[i]) acc = (acc * sq) % m;
               sq = (sq * sq) % m;
            end
            acc = acc % m;
         end
         outcome.power_result  = acc[WIDTH-1:0];
         outcome.modulus_error = 1'b0;
         return outcome;
      endfunction

      function void note_input(logic [WIDTH-1:0] b, logic [WIDTH-1:0] e);
         owed_results.push_back(predict_power(b, e));
      endfunction

      function void check_result(logic [WIDTH-1:0] power, logic err);
         mexp_outcome_type want;
         results_seen++;
         if (owed_results.size() == 0) begin
            $display("%0t: result with none outstanding, actual %h err %b", $time, power, err);
            mismatches++;
            return;
         end
         want = owed_results.pop_front();
         if (power !== want.power_result) begin
            $display("%0t: power_result mismatch, expected %h, actual %h",
                     $time, want.power_result, power);
            mismatches++;
         end
         if (err !== want.modulus_error) begin
            $display("%0t: modulus_error mismatch, expected %b, actual %b",
                     $time, want.modulus_error, err);
            mismatches++;
         end
      endfunction

      function int pending();
         return owed_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   mexp_req_if #(.WIDTH(WIDTH)) req_ch ();
   mexp_rsp_if #(.WIDTH(WIDTH)) rsp_ch ();
   mexp_csr_if #(.WIDTH(WIDTH)) csr_ch ();

   modular_exponentiation_unit #(
      .WIDTH(WIDTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   power_board_type board;
   bit              idle_on  = 1'b1;
   bit              hold_rsp = 1'b0;
   int              items_sent;
   int              mod_writes;

   // Clock, 10 ns period
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Drive every input to a known value from the start
   initial begin
      reset            <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.base_value <= '0;
      req_ch.exponent   <= '0;
      rsp_ch.ready      <= 1'b0;
      csr_ch.valid      <= 1'b0;
      csr_ch.modulus    <= '0;
   end

   // Offer one item, with an occasional gap ahead of it, and hold it until taken
   task automatic send_item(input logic [WIDTH-1:0] b, input logic [WIDTH-1:0] e);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.base_value <= b;
      req_ch.exponent   <= e;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_input(b, e);
      items_sent++;
   endtask

   // Drain outstanding results, then write the modulus while the unit is idle
   task automatic write_modulus(input logic [WIDTH-1:0] value);
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_ch.valid   <= 1'b1;
      csr_ch.modulus <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      board.set_modulus(value);
      mod_writes++;
   endtask

   function automatic logic [WIDTH-1:0] pick_base(logic [WIDTH-1:0] m);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 1;
         2: return '1;
         3: return m - 1;
         4: return m;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [WIDTH-1:0] pick_exponent();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 1;
         2: return '1;
         3, 4, 5: return $urandom_range(2, 255);
         default: return $urandom;
      endcase
   endfunction

   // Result side: check each accepted item, stall in bursts, hold off once
   initial begin
      int stall_left;
      stall_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.power_result, rsp_ch.modulus_error);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run after too many cycles with no handshake
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      @(negedge reset);
      while (quiet_cycles < WATCHDOG) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG);
      $display("CHECKS FAILED");
      $finish;
   end

   // Main stimulus
   initial begin
      logic [WIDTH-1:0] mod_plan[8];
      board      = new();
      items_sent = 0;
      mod_writes = 0;

      mod_plan[0] = '1;
      mod_plan[1] = '0;
      mod_plan[2] = 1;
      mod_plan[3] = 32'd3233;
      mod_plan[4] = 32'h8000_0000 | $urandom;
      mod_plan[5] = $urandom_range(2, 65535);
      mod_plan[6] = 32'hFFFF_FFFB;
      mod_plan[7] = 2;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset modulus of one: zero exponent gives 1, otherwise 0
      send_item(32'd5, 32'd0);
      send_item(32'd0, 32'd0);
      send_item(32'd7, 32'd5);
      send_item('1, '1);

      // Zero modulus flags an error whatever the exponent
      write_modulus('0);
      send_item(32'd3, 32'd0);
      send_item('1, '1);
      send_item(32'd0, 32'd1);

      // Small textbook key: encrypt, decrypt, base equal to and just below modulus
      write_modulus(32'd3233);
      send_item(32'd65, 32'd17);
      send_item(32'd2790, 32'd2753);
      send_item(32'd3233, 32'd1);
      send_item(32'd3232, 32'd2);

      // All-ones modulus: widest products and reductions
      write_modulus('1);
      send_item('1, '1);
      send_item(32'hFFFF_FFFE, 32'd2);
      send_item(32'd2, 32'd31);
      send_item(32'd2, 32'd32);
      send_item(32'd0, 32'd0);
      send_item(32'd1, '1);
      send_item(32'h1234_5678, 32'h8000_0000);

      write_modulus(32'd2);
      send_item(32'd3, '1);
      send_item(32'd0, 32'd7);

      // Random items over a range of moduli
      foreach (mod_plan[p]) begin
         write_modulus(mod_plan[p]);
         repeat (12) send_item(pick_base(mod_plan[p]), pick_exponent());
      end

      // Back up the unit: hold off the result side while items keep coming
      write_modulus(32'd1000003);
      hold_rsp = 1'b1;
      repeat (10) send_item($urandom, $urandom_range(1, 15));

      // Last stretch with no idling on either side
      write_modulus($urandom);
      idle_on = 1'b0;
      repeat (16) send_item(pick_base(board.modulus), pick_exponent());

      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Covered %0d items, %0d results, %0d modulus writes incl. zero, one, all-ones.",
               items_sent, board.results_seen, mod_writes);
      $display("Result side held off once for %0d cycles to fill the unit.", HOLD_CYCLES);
      if (board.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
